>>> hdl/fdd_pkg.sv
package fdd_pkg;

  localparam int unsigned REM_W   = 48;
  localparam int unsigned POW_W   = 47;
  localparam int unsigned TRIAL_W = 50;
  localparam int unsigned EXP_W   = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SHIFT,
    ST_SEARCH,
    ST_DIGIT,
    ST_ROUND,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    TRIAL_HALF,
    TRIAL_X1,
    TRIAL_X2,
    TRIAL_X4,
    TRIAL_X8
  } trial_e;

  function automatic logic [POW_W-1:0] pow10(input logic [3:0] pos);
    logic [POW_W-1:0] p;
    case (pos)
      4'd0:    p = 47'd100000000000000;
      4'd1:    p = 47'd10000000000000;
      4'd2:    p = 47'd1000000000000;
      4'd3:    p = 47'd100000000000;
      4'd4:    p = 47'd10000000000;
      4'd5:    p = 47'd1000000000;
      4'd6:    p = 47'd100000000;
      4'd7:    p = 47'd10000000;
      4'd8:    p = 47'd1000000;
      4'd9:    p = 47'd100000;
      4'd10:   p = 47'd10000;
      4'd11:   p = 47'd1000;
      4'd12:   p = 47'd100;
      4'd13:   p = 47'd10;
      4'd14:   p = 47'd1;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [31:0] scale_factor(input logic [4:0] idx);
    logic [31:0] s;
    case (idx)
      5'd0:    s = 32'd2295887404;
      5'd1:    s = 32'd587747175;
      5'd2:    s = 32'd1504632769;
      5'd3:    s = 32'd3851859889;
      5'd4:    s = 32'd986076132;
      5'd5:    s = 32'd2524354897;
      5'd6:    s = 32'd646234854;
      5'd7:    s = 32'd1654361225;
      5'd8:    s = 32'd4235164736;
      5'd9:    s = 32'd1084202172;
      5'd10:   s = 32'd2775557562;
      5'd11:   s = 32'd710542736;
      5'd12:   s = 32'd1818989404;
      5'd13:   s = 32'd465661287;
      5'd14:   s = 32'd1192092896;
      5'd15:   s = 32'd3051757813;
      5'd16:   s = 32'd781250000;
      5'd17:   s = 32'd2000000000;
      5'd18:   s = 32'd512000000;
      5'd19:   s = 32'd1310720000;
      5'd20:   s = 32'd3355443200;
      5'd21:   s = 32'd858993459;
      5'd22:   s = 32'd2199023256;
      5'd23:   s = 32'd562949953;
      5'd24:   s = 32'd1441151881;
      5'd25:   s = 32'd3689348815;
      5'd26:   s = 32'd944473297;
      5'd27:   s = 32'd2417851639;
      5'd28:   s = 32'd618970020;
      5'd29:   s = 32'd1584563250;
      5'd30:   s = 32'd4056481921;
      default: s = 32'd1038459372;
    endcase
    return s;
  endfunction

  function automatic logic signed [EXP_W-1:0] dec_exp(input logic [4:0] idx);
    logic signed [EXP_W-1:0] e;
    case (idx)
      5'd0:    e = -7'sd36;
      5'd1:    e = -7'sd33;
      5'd2:    e = -7'sd31;
      5'd3:    e = -7'sd29;
      5'd4:    e = -7'sd26;
      5'd5:    e = -7'sd24;
      5'd6:    e = -7'sd21;
      5'd7:    e = -7'sd19;
      5'd8:    e = -7'sd17;
      5'd9:    e = -7'sd14;
      5'd10:   e = -7'sd12;
      5'd11:   e = -7'sd9;
      5'd12:   e = -7'sd7;
      5'd13:   e = -7'sd4;
      5'd14:   e = -7'sd2;
      5'd15:   e = 7'sd0;
      5'd16:   e = 7'sd3;
      5'd17:   e = 7'sd5;
      5'd18:   e = 7'sd8;
      5'd19:   e = 7'sd10;
      5'd20:   e = 7'sd12;
      5'd21:   e = 7'sd15;
      5'd22:   e = 7'sd17;
      5'd23:   e = 7'sd20;
      5'd24:   e = 7'sd22;
      5'd25:   e = 7'sd24;
      5'd26:   e = 7'sd27;
      5'd27:   e = 7'sd29;
      5'd28:   e = 7'sd32;
      5'd29:   e = 7'sd34;
      5'd30:   e = 7'sd36;
      default: e = 7'sd39;
    endcase
    return e;
  endfunction

endpackage

>>> hdl/fdd_sub_unit.sv
module fdd_sub_unit (
  input  logic [fdd_pkg::REM_W-1:0] rem_i,
  input  logic [3:0]                pos_i,
  input  fdd_pkg::trial_e           mode_i,
  output logic                      ge_o,
  output logic [fdd_pkg::REM_W-1:0] diff_o
);

  logic [fdd_pkg::TRIAL_W-1:0] base;
  logic [fdd_pkg::TRIAL_W-1:0] trial;
  logic [fdd_pkg::TRIAL_W-1:0] rem_ext;
  logic [fdd_pkg::TRIAL_W-1:0] full;

  assign base    = {3'b000, fdd_pkg::pow10(pos_i)};
  assign rem_ext = {2'b00, rem_i};

  always_comb begin
    case (mode_i)
      fdd_pkg::TRIAL_HALF: trial = base >> 1;
      fdd_pkg::TRIAL_X1:   trial = base;
      fdd_pkg::TRIAL_X2:   trial = base << 1;
      fdd_pkg::TRIAL_X4:   trial = base << 2;
      fdd_pkg::TRIAL_X8:   trial = base << 3;
      default:             trial = base;
    endcase
  end

  assign full   = rem_ext - trial;
  assign ge_o   = (rem_ext >= trial);
  assign diff_o = full[fdd_pkg::REM_W-1:0];

endmodule

>>> hdl/float_to_decimal_digits_core.sv
// channel  direction  handshake                 payload
// input    in         start high, busy low      float_bits_i, precision_i, max_decimals_i
// result   out        done_o strobe, one cycle  digits_o, digit_count_o, exponent_o, flags
//
// a zero input goes straight to the finish step for its result beat; any other input passes
// through multiply, shift, up to 15 leading-zero compares, four compare-subtract steps per
// digit (no compare-subtract for digits past the units place), then a round check and finish
// busy is low in the result cycle, so the next beat can be taken at the result edge
// all compares and subtracts share one 50-bit compare-subtract unit
// reset clears the sequencer and the strobe; the receiver cannot stall the result
module float_to_decimal_digits_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       float_bits_i,
  input  logic [7:0]        precision_i,
  input  logic [5:0]        max_decimals_i,
  output logic              done_o,
  output logic [31:0]       digits_o,
  output logic [3:0]        digit_count_o,
  output logic signed [6:0] exponent_o,
  output logic              is_negative_o,
  output logic              is_zero_o,
  output logic              is_infinite_o,
  output logic              is_nan_o,
  output logic              carried_o
);

  fdd_pkg::state_e state_q, state_d;

  logic [23:0]                     frac_q, frac_d;
  logic [2:0]                      se3_q, se3_d;
  logic [31:0]                     scale_q, scale_d;
  logic [55:0]                     prod_q, prod_d;
  logic [fdd_pkg::REM_W-1:0]       rem_q, rem_d;
  logic signed [fdd_pkg::EXP_W-1:0] x10_q, x10_d;
  logic [4:0]                      pos_q, pos_d;
  logic [2:0]                      k_q, k_d;
  logic [3:0]                      n_q, n_d;
  logic [1:0]                      bit_q, bit_d;
  logic [2:0]                      quo_q, quo_d;
  logic [31:0]                     dig_q, dig_d;
  logic [2:0]                      prec_q, prec_d;
  logic [5:0]                      md_q, md_d;
  logic                            rnd_q, rnd_d;
  logic                            neg_q, neg_d;
  logic                            zero_q, zero_d;
  logic                            inf_q, inf_d;
  logic                            nan_q, nan_d;

  logic                            done_q, done_d;
  logic [31:0]                     out_dig_q, out_dig_d;
  logic [3:0]                      out_cnt_q, out_cnt_d;
  logic signed [6:0]               out_exp_q, out_exp_d;
  logic                            out_carry_q, out_carry_d;

  fdd_pkg::trial_e                 mode;
  logic                            ge;
  logic [fdd_pkg::REM_W-1:0]       diff;

  logic                            accept;
  logic                            past_units;
  logic                            last_digit;
  logic [7:0]                      ef;
  logic [22:0]                     frac_in;
  logic [7:0]                      se;
  logic [55:0]                     shifted;
  logic [7:0]                      lim;
  logic [3:0]                      n_sel;
  logic [31:0]                     inc_dig;
  logic                            inc_carry;
  logic                            c;
  logic [3:0]                      nib;

  assign busy       = (state_q != fdd_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign ef         = float_bits_i[30:23];
  assign frac_in    = float_bits_i[22:0];
  assign se         = (ef != 8'd0) ? ef : 8'd1;
  assign past_units = (pos_q > 5'd14);
  assign last_digit = ({1'b0, k_q} == n_q - 4'd1);
  assign shifted    = prod_q >> (4'd15 - {1'b0, se3_q});

  always_comb begin
    case (state_q)
      fdd_pkg::ST_SEARCH: mode = fdd_pkg::TRIAL_X1;
      fdd_pkg::ST_ROUND:  mode = fdd_pkg::TRIAL_HALF;
      fdd_pkg::ST_DIGIT: begin
        case (bit_q)
          2'd3:    mode = fdd_pkg::TRIAL_X8;
          2'd2:    mode = fdd_pkg::TRIAL_X4;
          2'd1:    mode = fdd_pkg::TRIAL_X2;
          default: mode = fdd_pkg::TRIAL_X1;
        endcase
      end
      default:            mode = fdd_pkg::TRIAL_X1;
    endcase
  end

  fdd_sub_unit u_sub (
    .rem_i  (rem_q),
    .pos_i  (pos_q[3:0]),
    .mode_i (mode),
    .ge_o   (ge),
    .diff_o (diff)
  );

  // digit count from the final exponent
  always_comb begin
    lim = {2'b00, md_q} + (x10_q[6] ? 8'd0 : {1'b0, x10_q});
    if (md_q == 6'd0) begin
      n_sel = {1'b0, prec_q} + 4'd1;
    end else if ({5'b0, prec_q} < lim) begin
      n_sel = {1'b0, prec_q};
    end else begin
      n_sel = lim[3:0];
    end
    if (n_sel == 4'd0) begin
      n_sel = 4'd1;
    end
  end

  // round-half-up increment of the last digit
  always_comb begin
    inc_dig = dig_q;
    c       = 1'b0;
    nib     = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      if (4'(i) == n_q - 4'd1) begin
        c = rnd_q;
      end
      nib = inc_dig[28-4*i +: 4];
      if (c) begin
        if (nib == 4'd9) begin
          nib = 4'd0;
        end else begin
          nib = nib + 4'd1;
          c   = 1'b0;
        end
      end
      inc_dig[28-4*i +: 4] = nib;
    end
    inc_carry = c;
    if (c) begin
      inc_dig[31:28] = 4'd1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fdd_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (ef == 8'd0 && frac_in == 23'd0) ? fdd_pkg::ST_FINISH
                                                     : fdd_pkg::ST_MUL;
        end
      end
      fdd_pkg::ST_MUL:    state_d = fdd_pkg::ST_SHIFT;
      fdd_pkg::ST_SHIFT:  state_d = fdd_pkg::ST_SEARCH;
      fdd_pkg::ST_SEARCH: begin
        if (ge || pos_q == 5'd14) begin
          state_d = fdd_pkg::ST_DIGIT;
        end
      end
      fdd_pkg::ST_DIGIT: begin
        if ((past_units || bit_q == 2'd0) && last_digit) begin
          state_d = fdd_pkg::ST_ROUND;
        end
      end
      fdd_pkg::ST_ROUND:  state_d = fdd_pkg::ST_FINISH;
      fdd_pkg::ST_FINISH: state_d = fdd_pkg::ST_IDLE;
      default:            state_d = fdd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    frac_d      = frac_q;
    se3_d       = se3_q;
    scale_d     = scale_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    x10_d       = x10_q;
    pos_d       = pos_q;
    k_d         = k_q;
    n_d         = n_q;
    bit_d       = bit_q;
    quo_d       = quo_q;
    dig_d       = dig_q;
    prec_d      = prec_q;
    md_d        = md_q;
    rnd_d       = rnd_q;
    neg_d       = neg_q;
    zero_d      = zero_q;
    inf_d       = inf_q;
    nan_d       = nan_q;
    done_d      = 1'b0;
    out_dig_d   = out_dig_q;
    out_cnt_d   = out_cnt_q;
    out_exp_d   = out_exp_q;
    out_carry_d = out_carry_q;
    case (state_q)
      fdd_pkg::ST_IDLE: begin
        if (accept) begin
          frac_d  = {(ef != 8'd0), frac_in};
          se3_d   = se[2:0];
          scale_d = fdd_pkg::scale_factor(se[7:3]);
          x10_d   = fdd_pkg::dec_exp(se[7:3]);
          prec_d  = (precision_i > 8'd7) ? 3'd7 : precision_i[2:0];
          md_d    = max_decimals_i;
          neg_d   = float_bits_i[31];
          zero_d  = (ef == 8'd0 && frac_in == 23'd0);
          inf_d   = (ef == 8'hff && frac_in == 23'd0);
          nan_d   = (ef == 8'hff && frac_in != 23'd0);
          pos_d   = 5'd0;
          k_d     = 3'd0;
          bit_d   = 2'd3;
          quo_d   = 3'd0;
          dig_d   = 32'd0;
          rnd_d   = 1'b0;
        end
      end
      fdd_pkg::ST_MUL: begin
        prod_d = {32'd0, frac_q} * {24'd0, scale_q};
      end
      fdd_pkg::ST_SHIFT: begin
        rem_d = shifted[fdd_pkg::REM_W-1:0];
      end
      fdd_pkg::ST_SEARCH: begin
        if (ge || pos_q == 5'd14) begin
          n_d = n_sel;
        end else begin
          pos_d = pos_q + 5'd1;
          x10_d = x10_q - 7'sd1;
        end
      end
      fdd_pkg::ST_DIGIT: begin
        if (past_units) begin
          if (!last_digit) begin
            k_d   = k_q + 3'd1;
            pos_d = pos_q + 5'd1;
          end
        end else begin
          if (ge) begin
            rem_d = diff;
          end
          if (bit_q != 2'd0) begin
            quo_d = {quo_q[1:0], ge};
            bit_d = bit_q - 2'd1;
          end else begin
            for (int i = 0; i < 8; i++) begin
              if (k_q == 3'(i)) begin
                dig_d[28-4*i +: 4] = {quo_q, ge};
              end
            end
            quo_d = 3'd0;
            bit_d = 2'd3;
            if (!last_digit) begin
              k_d   = k_q + 3'd1;
              pos_d = pos_q + 5'd1;
            end
          end
        end
      end
      fdd_pkg::ST_ROUND: begin
        rnd_d = (pos_q < 5'd14) && ge;
      end
      fdd_pkg::ST_FINISH: begin
        done_d = 1'b1;
        if (zero_q) begin
          out_dig_d   = 32'd0;
          out_cnt_d   = {1'b0, prec_q} + 4'd1;
          out_exp_d   = 7'sd0;
          out_carry_d = 1'b0;
        end else begin
          out_dig_d   = inc_dig;
          out_cnt_d   = n_q;
          out_exp_d   = x10_q + {6'd0, inc_carry};
          out_carry_d = inc_carry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdd_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frac_q      <= frac_d;
    se3_q       <= se3_d;
    scale_q     <= scale_d;
    prod_q      <= prod_d;
    rem_q       <= rem_d;
    x10_q       <= x10_d;
    pos_q       <= pos_d;
    k_q         <= k_d;
    n_q         <= n_d;
    bit_q       <= bit_d;
    quo_q       <= quo_d;
    dig_q       <= dig_d;
    prec_q      <= prec_d;
    md_q        <= md_d;
    rnd_q       <= rnd_d;
    neg_q       <= neg_d;
    zero_q      <= zero_d;
    inf_q       <= inf_d;
    nan_q       <= nan_d;
    out_dig_q   <= out_dig_d;
    out_cnt_q   <= out_cnt_d;
    out_exp_q   <= out_exp_d;
    out_carry_q <= out_carry_d;
  end

  assign done_o        = done_q;
  assign digits_o      = out_dig_q;
  assign digit_count_o = out_cnt_q;
  assign exponent_o    = out_exp_q;
  assign is_negative_o = neg_q;
  assign is_zero_o     = zero_q;
  assign is_infinite_o = inf_q;
  assign is_nan_o      = nan_q;
  assign carried_o     = out_carry_q;

endmodule
